// ===== hw/rtl/gfq_pkg.sv =====
// Shared types and constants for the gamepad frame qualifier.
package gfq_pkg;

  localparam int FRAME_W = 64;
  localparam int BTN_W = 12;
  localparam int AXIS_W = 8;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [AXIS_W-1:0] FAIL_THRESHOLD_RST = 8'd30;
  localparam logic [AXIS_W-1:0] STICK_MID = 8'd128;
  localparam logic [AXIS_W-1:0] COUNT_MAX = 8'd255;

  localparam logic [CFG_ADDR_W-1:0] REG_FAIL_THRESHOLD = 3'd0;

  localparam logic KIND_NORMAL = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic [AXIS_W-1:0] lx;
    logic [AXIS_W-1:0] ly;
    logic [AXIS_W-1:0] rx;
    logic [AXIS_W-1:0] ry;
  } gfq_axes_t;

  typedef struct packed {
    logic              invalid;
    logic [BTN_W-1:0]  buttons;
    gfq_axes_t         raw;
    gfq_axes_t         sticks;
    logic [AXIS_W-1:0] lt;
    logic [AXIS_W-1:0] rt;
  } gfq_frame_t;

endpackage

// ===== hw/rtl/gfq_decode.sv =====
// Frame check, button mapping and stick centring for one raw frame.
module gfq_decode (
  input  logic [gfq_pkg::FRAME_W-1:0] frame,
  input  gfq_pkg::gfq_axes_t          centers,
  input  logic                        calibrated,
  output gfq_pkg::gfq_frame_t         dec
);
  import gfq_pkg::*;

  logic [FRAME_W-1:0] inv;
  gfq_axes_t          ctr;
  logic [AXIS_W-1:0]  clx;
  logic [AXIS_W-1:0]  cly;
  logic [AXIS_W-1:0]  crx;
  logic [AXIS_W-1:0]  cry;

  function automatic logic [AXIS_W-1:0] center_clamp(input logic [AXIS_W-1:0] raw,
                                                     input logic [AXIS_W-1:0] ctr_val);
    logic signed [AXIS_W+1:0] v;
    begin
      v = $signed({2'b00, raw}) - $signed({2'b00, ctr_val}) + $signed({2'b00, STICK_MID});
      if (v < 0) begin
        center_clamp = '0;
      end else if (v > $signed({2'b00, COUNT_MAX})) begin
        center_clamp = COUNT_MAX;
      end else begin
        center_clamp = v[AXIS_W-1:0];
      end
    end
  endfunction

  assign inv = ~frame;

  always_comb begin
    dec = '0;
    dec.invalid = (frame == '0) || (frame == '1);
    dec.buttons = {inv[13], inv[12], inv[10], inv[8], inv[7:0]};
    dec.raw.lx = inv[23:16];
    dec.raw.ly = inv[31:24];
    dec.raw.rx = inv[39:32];
    dec.raw.ry = inv[47:40];
    dec.lt = inv[55:48];
    dec.rt = inv[63:56];
    ctr = calibrated ? centers : dec.raw;
    clx = center_clamp(dec.raw.lx, ctr.lx);
    cly = center_clamp(dec.raw.ly, ctr.ly);
    crx = center_clamp(dec.raw.rx, ctr.rx);
    cry = center_clamp(dec.raw.ry, ctr.ry);
    dec.sticks.lx = clx;
    dec.sticks.ly = ~cly;
    dec.sticks.rx = crx;
    dec.sticks.ry = ~cry;
  end

endmodule

// ===== hw/rtl/gamepad_frame_qualifier.sv =====
// Top level of the gamepad frame qualifier: frame register, state and report register.
//
// The input stream carries one raw 64-bit active-low controller frame per transfer.
// Each frame is taken into an input register, checked and decoded by short logic,
// and its report, if any, is written into the output register. A new frame is
// accepted in every cycle while the output side keeps up: one frame per cycle sustained.
// A frame of all ones or all zeros counts as a failure; once the failure count
// reaches fail_threshold while connected, one release-all report (tuser high,
// no buttons, sticks at 128, triggers at 0) is sent. Valid frames report only
// when the buttons or sticks change; the first valid frame after reset or a
// disconnect captures the stick centres.
// When the receiver stalls, the report waits in the output register, the frame
// behind it waits in the input register, and in_tready falls only then or in reset.
// Reset clears control state, not data registers, and sets fail_threshold to 30. The user
// sets it through the APB port at address 0 only while idle; the block does not enforce it.
module gamepad_frame_qualifier (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gfq_pkg::FRAME_W-1:0]      in_tdata,   // raw_frame[63:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gfq_pkg::OUT_DATA_W-1:0]   out_tdata,  // button_bits[11:0], left_x, left_y,
                                                       // right_x, right_y, left_trigger,
                                                       // right_trigger, 4 zero bits
  output logic                             out_tuser,  // report_kind
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [gfq_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [gfq_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [gfq_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import gfq_pkg::*;

  logic                  in_valid_r;
  logic [FRAME_W-1:0]    frame_r;
  logic [AXIS_W-1:0]     thr_r;
  logic                  conn_r;
  logic                  cal_r;
  logic [AXIS_W-1:0]     cnt_r;
  gfq_axes_t             ctr_r;
  logic [BTN_W-1:0]      last_btn_r;
  gfq_axes_t             last_stk_r;
  logic                  known_r;
  logic                  out_valid_r;
  logic                  out_kind_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  conn_nxt;
  logic                  cal_nxt;
  logic [AXIS_W-1:0]     cnt_nxt;
  gfq_axes_t             ctr_nxt;
  logic [BTN_W-1:0]      last_btn_nxt;
  gfq_axes_t             last_stk_nxt;
  logic                  known_nxt;
  logic                  emit;
  logic                  emit_kind;
  logic [OUT_DATA_W-1:0] emit_data;

  logic                  advance;
  logic                  cfg_wr;
  logic [AXIS_W-1:0]     cnt_inc;
  gfq_frame_t            dec;

  gfq_decode u_decode (
    .frame      (frame_r),
    .centers    (ctr_r),
    .calibrated (cal_r),
    .dec        (dec)
  );

  assign advance = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!in_valid_r || advance);
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[CFG_ADDR_W-1:2] == REG_FAIL_THRESHOLD[CFG_ADDR_W-1:2]);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_FAIL_THRESHOLD[CFG_ADDR_W-1:2]) ?
                      {{(CFG_DATA_W-AXIS_W){1'b0}}, thr_r} : '0;
  assign cnt_inc = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 8'd1;

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_kind_r;

  always_comb begin
    conn_nxt = conn_r;
    cal_nxt = cal_r;
    cnt_nxt = cnt_r;
    ctr_nxt = ctr_r;
    last_btn_nxt = last_btn_r;
    last_stk_nxt = last_stk_r;
    known_nxt = known_r;
    emit = 1'b0;
    emit_kind = KIND_NORMAL;
    emit_data = '0;
    if (dec.invalid) begin
      cnt_nxt = cnt_inc;
      if ((cnt_inc >= thr_r) && conn_r) begin
        conn_nxt = 1'b0;
        cal_nxt = 1'b0;
        last_btn_nxt = '0;
        last_stk_nxt = '0;
        known_nxt = 1'b1;
        emit = 1'b1;
        emit_kind = KIND_RELEASE;
        emit_data = {4'b0, 8'd0, 8'd0, STICK_MID, STICK_MID, STICK_MID, STICK_MID,
                     {BTN_W{1'b0}}};
      end
    end else begin
      cnt_nxt = '0;
      conn_nxt = 1'b1;
      if (!cal_r) begin
        ctr_nxt = dec.raw;
        cal_nxt = 1'b1;
      end
      if (!known_r || (dec.buttons != last_btn_r) || (dec.sticks != last_stk_r)) begin
        last_btn_nxt = dec.buttons;
        last_stk_nxt = dec.sticks;
        known_nxt = 1'b1;
        emit = 1'b1;
        emit_kind = KIND_NORMAL;
        emit_data = {4'b0, dec.rt, dec.lt, dec.sticks.ry, dec.sticks.rx, dec.sticks.ly,
                     dec.sticks.lx, dec.buttons};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      thr_r <= FAIL_THRESHOLD_RST;
      conn_r <= 1'b0;
      cal_r <= 1'b0;
      cnt_r <= '0;
      ctr_r <= '0;
      last_btn_r <= '0;
      last_stk_r <= '0;
      known_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_kind_r <= KIND_NORMAL;
    end else begin
      if (cfg_wr) begin
        thr_r <= cfg_pwdata[AXIS_W-1:0];
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        conn_r <= conn_nxt;
        cal_r <= cal_nxt;
        cnt_r <= cnt_nxt;
        ctr_r <= ctr_nxt;
        last_btn_r <= last_btn_nxt;
        last_stk_r <= last_stk_nxt;
        known_r <= known_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
        out_kind_r <= emit_kind;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      frame_r <= in_tdata;
    end
    if (advance && emit) begin
      out_data_r <= emit_data;
    end
  end

endmodule

// ===== dv/tb_gamepad_frame_qualifier.sv =====
// Self-checking testbench for the gamepad frame qualifier: directed and random frames.
module tb_gamepad_frame_qualifier;
  timeunit 1ns;
  timeprecision 1ps;

  import gfq_pkg::*;

  localparam int RANDOM_ITEMS = 220;
  localparam int SETTLE_CYCLES = 6;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic              kind;
    logic [BTN_W-1:0]  buttons;
    logic [AXIS_W-1:0] lx;
    logic [AXIS_W-1:0] ly;
    logic [AXIS_W-1:0] rx;
    logic [AXIS_W-1:0] ry;
    logic [AXIS_W-1:0] lt;
    logic [AXIS_W-1:0] rt;
  } report_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [FRAME_W-1:0]    in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Predictor state.
  logic [AXIS_W-1:0] pred_fail_threshold;
  logic              pred_connected;
  logic              pred_calibrated;
  logic [AXIS_W-1:0] pred_fail_count;
  logic [AXIS_W-1:0] pred_centre [4];
  logic [BTN_W-1:0]  pred_last_buttons;
  logic [31:0]       pred_last_sticks;
  logic              pred_last_known;

  report_t expected_reports[$];
  int n_errors;
  int n_frames;
  int n_reports;
  int n_releases;
  int n_threshold_writes;
  int n_cycles;
  int gap_pct;
  int stall_pct;
  bit calm;

  gamepad_frame_qualifier u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("gamepad_frame_qualifier: mismatch");
      $finish;
    end
  end

  function automatic logic [AXIS_W-1:0] centre_axis(input logic [AXIS_W-1:0] raw,
                                                    input logic [AXIS_W-1:0] centre);
    int v;
    v = int'(raw) - int'(centre) + int'(STICK_MID);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[AXIS_W-1:0];
  endfunction

  function automatic bit predict_report(input logic [FRAME_W-1:0] frame, output report_t rep);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] axis [4];
    logic [BTN_W-1:0] buttons;
    logic [31:0] sticks;
    rep = '0;
    if (frame == '1 || frame == '0) begin
      if (pred_fail_count != COUNT_MAX) pred_fail_count++;
      if (pred_fail_count >= pred_fail_threshold && pred_connected) begin
        pred_connected = 1'b0;
        pred_calibrated = 1'b0;
        pred_last_buttons = '0;
        pred_last_sticks = '0;
        pred_last_known = 1'b1;
        rep.kind = KIND_RELEASE;
        rep.lx = STICK_MID;
        rep.ly = STICK_MID;
        rep.rx = STICK_MID;
        rep.ry = STICK_MID;
        return 1'b1;
      end
      return 1'b0;
    end
    pred_fail_count = '0;
    pred_connected = 1'b1;
    for (int k = 0; k < 4; k++) axis[k] = ~frame[8*(k+2) +: 8];
    if (!pred_calibrated) begin
      for (int k = 0; k < 4; k++) pred_centre[k] = axis[k];
      pred_calibrated = 1'b1;
    end
    b0 = ~frame[7:0];
    b1 = ~frame[15:8];
    buttons = {b1[5], b1[4], b1[2], b1[0], b0};
    rep.kind = KIND_NORMAL;
    rep.buttons = buttons;
    rep.lx = centre_axis(axis[0], pred_centre[0]);
    rep.ly = ~centre_axis(axis[1], pred_centre[1]);
    rep.rx = centre_axis(axis[2], pred_centre[2]);
    rep.ry = ~centre_axis(axis[3], pred_centre[3]);
    rep.lt = ~frame[55:48];
    rep.rt = ~frame[63:56];
    sticks = {rep.lx, rep.ly, rep.rx, rep.ry};
    if (pred_last_known && buttons == pred_last_buttons && sticks == pred_last_sticks)
      return 1'b0;
    pred_last_buttons = buttons;
    pred_last_sticks = sticks;
    pred_last_known = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [FRAME_W-1:0] pack_frame(input logic [7:0] b0, input logic [7:0] b1,
                                                    input logic [7:0] lx, input logic [7:0] ly,
                                                    input logic [7:0] rx, input logic [7:0] ry,
                                                    input logic [7:0] lt, input logic [7:0] rt);
    return {rt, lt, ry, rx, ly, lx, b1, b0};
  endfunction

  function automatic logic [FRAME_W-1:0] make_valid(input logic [FRAME_W-1:0] f);
    if (f == '1 || f == '0) return f ^ (64'd1 << 16);
    return f;
  endfunction

  task automatic note_mismatch(input string why, input report_t want, input report_t got);
    n_errors++;
    if (n_errors <= 10)
      $display({"%0t %s: expected kind %0b btn %h sticks %h %h %h %h trig %h %h, ",
                "got kind %0b btn %h sticks %h %h %h %h trig %h %h"},
               $realtime, why, want.kind, want.buttons, want.lx, want.ly, want.rx, want.ry,
               want.lt, want.rt, got.kind, got.buttons, got.lx, got.ly, got.rx, got.ry,
               got.lt, got.rt);
  endtask

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.buttons = out_tdata[11:0];
      got.lx = out_tdata[19:12];
      got.ly = out_tdata[27:20];
      got.rx = out_tdata[35:28];
      got.ry = out_tdata[43:36];
      got.lt = out_tdata[51:44];
      got.rt = out_tdata[59:52];
      n_reports++;
      if (got.kind == KIND_RELEASE) n_releases++;
      if (expected_reports.size() == 0) begin
        note_mismatch("unexpected report", '0, got);
      end else begin
        want = expected_reports.pop_front();
        if (got.kind !== want.kind || got.buttons !== want.buttons ||
            got.lx !== want.lx || got.ly !== want.ly || got.rx !== want.rx ||
            got.ry !== want.ry || got.lt !== want.lt || got.rt !== want.rt)
          note_mismatch("report differs", want, got);
      end
    end
  end

  always begin
    @(posedge clk);
    if (!calm && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    out_tready <= 1'b1;
  end

  task automatic send_frame(input logic [FRAME_W-1:0] f);
    report_t rep;
    if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= f;
    do @(posedge clk); while (!in_tready);
    n_frames++;
    if (predict_report(f, rep)) expected_reports.push_back(rep);
  endtask

  task automatic drain_reports();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_fail_threshold(input logic [AXIS_W-1:0] value);
    drain_reports();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_FAIL_THRESHOLD;
    cfg_pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    pred_fail_threshold = value;
    n_threshold_writes++;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[AXIS_W-1:0] !== value) begin
      n_errors++;
      if (n_errors <= 10)
        $display("%0t threshold read back: expected %h, got %h", $realtime, value, cfg_prdata);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic send_invalid_run(input int count);
    for (int i = 0; i < count; i++) send_frame($urandom_range(0, 1) ? '1 : '0);
  endtask

  task automatic test_reports_on_change();
    logic [7:0] b0;
    logic [7:0] b1;
    send_frame(pack_frame(8'hFF, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hFF));
    send_frame(pack_frame(8'hFF, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hFF));
    send_frame(pack_frame(8'hFF, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 8'h12));
    send_frame(pack_frame(8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00));
    send_frame(pack_frame(8'hFF, 8'hCA, 8'h80, 8'h80, 8'h80, 8'h80, 8'h5A, 8'hA5));
    for (int i = 0; i < BTN_W; i++) begin
      b0 = 8'hFF;
      b1 = 8'hFF;
      case (i)
        8:       b1[0] = 1'b0;
        9:       b1[2] = 1'b0;
        10:      b1[4] = 1'b0;
        11:      b1[5] = 1'b0;
        default: b0[i] = 1'b0;
      endcase
      send_frame(pack_frame(b0, b1, 8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hFF));
    end
  endtask

  task automatic test_release_on_disconnect();
    send_invalid_run(int'(FAIL_THRESHOLD_RST) - 1);
    send_frame('0);
    send_invalid_run(4);
  endtask

  task automatic test_stick_clamping();
    set_fail_threshold(8'd1);
    send_frame(pack_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_frame(pack_frame(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF));
    send_frame(pack_frame(8'hFE, 8'hFF, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'hFF, 8'hFF));
    send_frame('1);
    send_frame(pack_frame(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF));
    send_frame(pack_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00));
    send_frame('0);
    send_frame('0);
  endtask

  task automatic test_count_saturation();
    set_fail_threshold(COUNT_MAX);
    send_frame(pack_frame(8'h7F, 8'hDF, 8'h40, 8'hC0, 8'h20, 8'hE0, 8'h80, 8'h01));
    send_invalid_run(262);
    send_frame(pack_frame(8'hFF, 8'hFF, 8'h10, 8'h90, 8'hF0, 8'h08, 8'hFF, 8'hFF));
  endtask

  task automatic test_random_sessions();
    int target;
    int thr;
    int len;
    int k;
    logic [FRAME_W-1:0] f;
    target = n_frames + RANDOM_ITEMS;
    while (n_frames < target) begin
      calm = (n_frames > target - 100);
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      case ($urandom_range(0, 5))
        0:       set_fail_threshold(8'd1);
        1:       set_fail_threshold(COUNT_MAX);
        5:       set_fail_threshold(AXIS_W'($urandom_range(1, 255)));
        default: set_fail_threshold(AXIS_W'($urandom_range(2, 8)));
      endcase
      thr = int'(pred_fail_threshold);
      repeat (8) begin
        case ($urandom_range(0, 9))
          6, 7: begin
            if (thr <= 16) len = $urandom_range((thr > 1) ? thr - 1 : 1, thr + 2);
            else len = $urandom_range(1, 6);
            send_invalid_run(len);
          end
          8: begin
            repeat ($urandom_range(2, 8)) begin
              case ($urandom_range(0, 3))
                0:       send_frame('1);
                1:       send_frame('0);
                default: send_frame({$urandom, $urandom});
              endcase
            end
          end
          9: drain_reports();
          default: begin
            f = make_valid({$urandom, $urandom});
            repeat ($urandom_range(3, 12)) begin
              case ($urandom_range(0, 5))
                0: ;
                1: f[63:48] = 16'($urandom);
                2: f ^= 64'd1 << $urandom_range(0, 15);
                3: begin
                  k = $urandom_range(2, 5);
                  f[8*k +: 8] = f[8*k +: 8] + 8'($urandom_range(0, 6)) - 8'd3;
                end
                4: f = {$urandom, $urandom};
                default: f ^= 64'd1 << $urandom_range(0, 63);
              endcase
              f = make_valid(f);
              send_frame(f);
            end
          end
        endcase
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    n_errors = 0;
    n_frames = 0;
    n_reports = 0;
    n_releases = 0;
    n_threshold_writes = 0;
    n_cycles = 0;
    gap_pct = 20;
    stall_pct = 20;
    calm = 1'b0;
    pred_fail_threshold = FAIL_THRESHOLD_RST;
    pred_connected = 1'b0;
    pred_calibrated = 1'b0;
    pred_fail_count = '0;
    for (int k = 0; k < 4; k++) pred_centre[k] = '0;
    pred_last_buttons = '0;
    pred_last_sticks = '0;
    pred_last_known = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reports_on_change();
    test_release_on_disconnect();
    test_stick_clamping();
    test_count_saturation();
    test_random_sessions();

    calm = 1'b1;
    drain_reports();
    $display("Run covered %0d frames and %0d threshold settings from 1 to 255.",
             n_frames, n_threshold_writes);
    $display("It checked %0d reports, %0d of them release reports.", n_reports, n_releases);
    if (n_errors == 0) begin
      $display("gamepad_frame_qualifier: match");
    end else begin
      $display("%0d mismatches in total.", n_errors);
      $display("gamepad_frame_qualifier: mismatch");
    end
    $finish;
  end

endmodule
